// ===== sv/jti_pkg.sv =====
// shared types, constants and codes for the joint trajectory interpolator
package jti_pkg;

  localparam int MaxStepsDefault = 64;

  localparam int PosW    = 16;
  localparam int DurW    = 7;
  localparam int ModeW   = 2;
  localparam int StatW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;
  localparam int InDataW  = 56;
  localparam int OutDataW = 48;

  localparam int MagW    = 16;
  localparam int NumW    = 19;
  localparam int ProdW   = NumW + MagW;
  localparam int DivW    = ProdW + 1;
  localparam int DvsW    = NumW + 1;
  localparam int QuoW    = 16;
  localparam int DivCntW = 4;
  localparam int UpcW    = 4;

  localparam logic [ModeW-1:0] MODE_LINEAR = 2'd0;
  localparam logic [ModeW-1:0] MODE_CUBIC  = 2'd1;

  localparam logic [CfgIdxW-1:0] CFG_ROT_LO  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROT_HI  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRIS_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRIS_HI = 2'd3;

  localparam logic signed [PosW-1:0] RotLoReset  = -16'sd12868;
  localparam logic signed [PosW-1:0] RotHiReset  = 16'sd12868;
  localparam logic signed [PosW-1:0] PrisLoReset = -16'sd614;
  localparam logic signed [PosW-1:0] PrisHiReset = 16'sd614;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_LIMIT    = 2'd1,
    ST_DURATION = 2'd2,
    ST_MODE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_WAIT     = 4'd0,
    OP_CHECK    = 4'd1,
    OP_SQ_N     = 4'd2,
    OP_DEN      = 4'd3,
    OP_SQ_K     = 4'd4,
    OP_NUM      = 4'd5,
    OP_MUL      = 4'd6,
    OP_DIV_LOAD = 4'd7,
    OP_DIV_STEP = 4'd8,
    OP_APPLY    = 4'd9,
    OP_EMIT     = 4'd10,
    OP_NEXT     = 4'd11,
    OP_COMMIT   = 4'd12,
    OP_ERROR    = 4'd13,
    OP_NOP      = 4'd14
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT       = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_REQ     = 3'd2,
    C_ERROR      = 3'd3,
    C_DIV_BUSY   = 3'd4,
    C_JOINT_MORE = 3'd5,
    C_OUT_WAIT   = 3'd6,
    C_K_MORE     = 3'd7
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [UpcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ===== sv/jti_div.sv =====
// restoring divider, one quotient bit per step
module jti_div (
  input  logic                     clk,
  input  logic                     rst,
  input  jti_pkg::div_ctrl_t       ctrl,
  input  logic [jti_pkg::DivW-1:0] dividend,
  input  logic [jti_pkg::DvsW-1:0] divisor,
  output logic [jti_pkg::QuoW-1:0] quotient,
  output logic                     done
);
  import jti_pkg::*;

  logic [DvsW-1:0]    rem;
  logic [QuoW-1:0]    quo;
  logic [DvsW-1:0]    dvs;
  logic [DivCntW-1:0] cnt;
  logic [DvsW:0]      trial;
  logic [DvsW:0]      diff;

  assign trial = {rem, quo[QuoW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= dividend[DivW-1:QuoW];
      quo <= dividend[QuoW-1:0];
      dvs <= divisor;
    end else if (ctrl.step) begin
      if (diff[DvsW] == 1'b0) begin
        rem <= diff[DvsW-1:0];
        quo <= {quo[QuoW-2:0], 1'b1};
      end else begin
        rem <= trial[DvsW-1:0];
        quo <= {quo[QuoW-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign done     = (cnt == {DivCntW{1'b1}});

endmodule

// ===== sv/joint_trajectory_interpolator_unit.sv =====
// top level: microcoded joint trajectory interpolator for a three-joint arm
//
// s_axis carries one move request: three Q3.12 joint targets and a duration N
// in tdata, the mode (linear or cubic) in tuser. m_axis returns the samples of
// the move, three Q3.12 positions in tdata and a status code in tuser, with
// tlast on the final sample. A request that fails the limit, duration or mode
// check returns one result carrying the held position and the error code.
// Control runs from a 16-word program ROM; one shared 19x16 multiplier and a
// one-bit-per-cycle divider do the arithmetic. Each move first runs the checks
// and forms the denominator (N, or N^3 when cubic); each sample then forms its
// scale factor, takes each joint through product, divider load, 16 divider
// steps and add, and then emits and advances. An error result is emitted
// straight after the checks.
// The program handles one request at a time; s_axis_tready is high only while
// it waits for a request. While m_axis_tready is low the current result holds
// and the program waits. Reset (synchronous) restores the limit registers to
// their defaults and the stored start position to zero.
module joint_trajectory_interpolator_unit #(
  parameter int MAX_STEPS = jti_pkg::MaxStepsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // target_joint1, target_joint2, target_joint3, duration_steps, zero pad
  input  logic [jti_pkg::InDataW-1:0]  s_axis_tdata,
  // mode
  input  logic [jti_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // pos_joint1, pos_joint2, pos_joint3
  output logic [jti_pkg::OutDataW-1:0] m_axis_tdata,
  // status
  output logic [jti_pkg::StatW-1:0]    m_axis_tuser,
  output logic                         m_axis_tlast,
  input  logic                         cfg_we,
  input  logic [jti_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [jti_pkg::CfgW-1:0]     cfg_data
);
  import jti_pkg::*;

  localparam logic [UpcW-1:0] U_WAIT  = 4'd0;
  localparam logic [UpcW-1:0] U_KLOOP = 4'd4;
  localparam logic [UpcW-1:0] U_JLOOP = 4'd6;
  localparam logic [UpcW-1:0] U_DIV   = 4'd8;
  localparam logic [UpcW-1:0] U_EMIT  = 4'd10;
  localparam logic [UpcW-1:0] U_ERR   = 4'd13;
  localparam logic [DurW-1:0] MaxN    = DurW'(MAX_STEPS);

  localparam uword_t Rom [16] = '{
    '{OP_WAIT,     C_NO_REQ,     U_WAIT},
    '{OP_CHECK,    C_ERROR,      U_ERR},
    '{OP_SQ_N,     C_NEXT,       U_WAIT},
    '{OP_DEN,      C_NEXT,       U_WAIT},
    '{OP_SQ_K,     C_NEXT,       U_WAIT},
    '{OP_NUM,      C_NEXT,       U_WAIT},
    '{OP_MUL,      C_NEXT,       U_WAIT},
    '{OP_DIV_LOAD, C_NEXT,       U_WAIT},
    '{OP_DIV_STEP, C_DIV_BUSY,   U_DIV},
    '{OP_APPLY,    C_JOINT_MORE, U_JLOOP},
    '{OP_EMIT,     C_OUT_WAIT,   U_EMIT},
    '{OP_NEXT,     C_K_MORE,     U_KLOOP},
    '{OP_COMMIT,   C_ALWAYS,     U_WAIT},
    '{OP_ERROR,    C_OUT_WAIT,   U_ERR},
    '{OP_NOP,      C_ALWAYS,     U_WAIT},
    '{OP_NOP,      C_ALWAYS,     U_WAIT}
  };

  logic [UpcW-1:0] upc;
  logic [UpcW-1:0] upc_next;
  uword_t          uw;
  logic            take;

  logic signed [PosW-1:0] rot_lo, rot_hi, pris_lo, pris_hi;
  logic signed [PosW-1:0] tgt [3];
  logic signed [PosW-1:0] cur [3];
  logic signed [PosW-1:0] pos [3];
  logic [MagW-1:0]        mag [3];
  logic                   neg [3];
  logic [DurW-1:0]        n;
  logic [DurW-1:0]        k;
  logic [ModeW-1:0]       mode;
  logic [1:0]             jdx;
  logic [ProdW-1:0]       p;
  logic [NumW-1:0]        den;
  logic [NumW-1:0]        num;
  status_t                status;

  logic                   lim_err, dur_err, mode_err, err_any;
  status_t                chk_status;
  logic [NumW-1:0]        mul_a;
  logic [MagW-1:0]        mul_b;
  logic [ProdW-1:0]       prod;
  logic [8:0]             tn_2k;
  logic [MagW-1:0]        mag_sel;
  logic                   neg_sel;
  logic signed [PosW-1:0] cur_sel;
  logic [PosW:0]          sum;
  logic                   cubic;

  div_ctrl_t              div_ctrl;
  logic [DivW-1:0]        dividend;
  logic [QuoW-1:0]        quotient;
  logic                   div_done;

  assign uw    = Rom[upc];
  assign cubic = (mode == MODE_CUBIC);

  // checks, in priority order: limits, duration, mode
  assign lim_err = (tgt[0] < rot_lo) || (tgt[0] > rot_hi) ||
                   (tgt[1] < rot_lo) || (tgt[1] > rot_hi) ||
                   (tgt[2] < pris_lo) || (tgt[2] > pris_hi);
  assign dur_err  = (n == '0) || (n > MaxN);
  assign mode_err = (mode != MODE_LINEAR) && (mode != MODE_CUBIC);
  assign err_any  = lim_err || dur_err || mode_err;

  always_comb begin
    if (lim_err) begin
      chk_status = ST_LIMIT;
    end else if (dur_err) begin
      chk_status = ST_DURATION;
    end else if (mode_err) begin
      chk_status = ST_MODE;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    unique case (jdx)
      2'd0: begin
        mag_sel = mag[0];
        neg_sel = neg[0];
        cur_sel = cur[0];
      end
      2'd1: begin
        mag_sel = mag[1];
        neg_sel = neg[1];
        cur_sel = cur[1];
      end
      default: begin
        mag_sel = mag[2];
        neg_sel = neg[2];
        cur_sel = cur[2];
      end
    endcase
  end

  // 3n - 2k, never below n
  assign tn_2k = ({2'b0, n} << 1) + {2'b0, n} - ({2'b0, k} << 1);

  always_comb begin
    unique case (uw.op)
      OP_SQ_N: begin
        mul_a = NumW'(n);
        mul_b = MagW'(n);
      end
      OP_DEN: begin
        mul_a = p[NumW-1:0];
        mul_b = MagW'(n);
      end
      OP_SQ_K: begin
        mul_a = NumW'(k);
        mul_b = MagW'(k);
      end
      OP_NUM: begin
        mul_a = p[NumW-1:0];
        mul_b = MagW'(tn_2k);
      end
      OP_MUL: begin
        mul_a = num;
        mul_b = mag_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  // round half away from zero: (2*|d|*num + den) / (2*den)
  assign dividend      = {p, 1'b0} + DivW'(den);
  assign div_ctrl.load = (uw.op == OP_DIV_LOAD);
  assign div_ctrl.step = (uw.op == OP_DIV_STEP);

  jti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (dividend),
    .divisor  ({den, 1'b0}),
    .quotient (quotient),
    .done     (div_done)
  );

  assign sum = neg_sel ? ({cur_sel[PosW-1], cur_sel} - {1'b0, quotient})
                       : ({cur_sel[PosW-1], cur_sel} + {1'b0, quotient});

  // sequencer
  always_comb begin
    case (uw.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_REQ:     take = !s_axis_tvalid;
      C_ERROR:      take = err_any;
      C_DIV_BUSY:   take = !div_done;
      C_JOINT_MORE: take = (jdx != 2'd2);
      C_OUT_WAIT:   take = !m_axis_tready;
      C_K_MORE:     take = (k != n);
      default:      take = 1'b0;
    endcase
    upc_next = take ? uw.target : upc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_WAIT;
    end else begin
      upc <= upc_next;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_lo  <= RotLoReset;
      rot_hi  <= RotHiReset;
      pris_lo <= PrisLoReset;
      pris_hi <= PrisHiReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROT_LO:  rot_lo  <= cfg_data;
        CFG_ROT_HI:  rot_hi  <= cfg_data;
        CFG_PRIS_LO: pris_lo <= cfg_data;
        CFG_PRIS_HI: pris_hi <= cfg_data;
        default: ;
      endcase
    end
  end

  // stored start position
  always_ff @(posedge clk) begin
    if (rst) begin
      cur[0] <= '0;
      cur[1] <= '0;
      cur[2] <= '0;
    end else if (uw.op == OP_COMMIT) begin
      cur[0] <= tgt[0];
      cur[1] <= tgt[1];
      cur[2] <= tgt[2];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (uw.op) inside
      OP_WAIT: begin
        if (s_axis_tvalid) begin
          tgt[0] <= s_axis_tdata[15:0];
          tgt[1] <= s_axis_tdata[31:16];
          tgt[2] <= s_axis_tdata[47:32];
          n      <= s_axis_tdata[54:48];
          mode   <= s_axis_tuser;
        end
      end
      OP_CHECK: begin
        for (int j = 0; j < 3; j++) begin
          logic [PosW:0] d;
          d      = {tgt[j][PosW-1], tgt[j]} - {cur[j][PosW-1], cur[j]};
          neg[j] <= d[PosW];
          mag[j] <= d[PosW] ? MagW'(-d) : d[MagW-1:0];
          pos[j] <= cur[j];
        end
        status <= chk_status;
        k      <= DurW'(1);
        jdx    <= 2'd0;
      end
      OP_SQ_N, OP_SQ_K, OP_MUL: begin
        p <= prod;
      end
      OP_DEN: begin
        den <= cubic ? prod[NumW-1:0] : NumW'(n);
      end
      OP_NUM: begin
        num <= cubic ? prod[NumW-1:0] : NumW'(k);
      end
      OP_APPLY: begin
        pos[jdx] <= sum[PosW-1:0];
        jdx      <= (jdx == 2'd2) ? 2'd0 : jdx + 1'b1;
      end
      OP_NEXT: begin
        k <= k + 1'b1;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (uw.op == OP_WAIT);
  assign m_axis_tvalid = (uw.op == OP_EMIT) || (uw.op == OP_ERROR);
  assign m_axis_tdata  = {pos[2], pos[1], pos[0]};
  assign m_axis_tuser  = status;
  assign m_axis_tlast  = (uw.op == OP_ERROR) || (k == n);

endmodule

// ===== bench/joint_trajectory_interpolator_unit_tb.sv =====
// self-checking bench for the joint trajectory interpolator: directed table, random moves, stalls
`timescale 1ns / 100ps

module joint_trajectory_interpolator_unit_tb;
  import jti_pkg::*;

  localparam logic [ModeW-1:0] MODE_BAD2 = 2'd2;
  localparam logic [ModeW-1:0] MODE_BAD3 = 2'd3;

  typedef struct packed {
    logic signed [PosW-1:0] t1;
    logic signed [PosW-1:0] t2;
    logic signed [PosW-1:0] t3;
    logic [DurW-1:0]        dur;
    logic [ModeW-1:0]       mode;
    bit                     typed;
    logic signed [PosW-1:0] e1;
    logic signed [PosW-1:0] e2;
    logic signed [PosW-1:0] e3;
    status_t                est;
  } drill_t;

  typedef struct packed {
    logic signed [PosW-1:0] p1;
    logic signed [PosW-1:0] p2;
    logic signed [PosW-1:0] p3;
    status_t                st;
    logic                   fin;
  } sample_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;
  logic [ModeW-1:0]     s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic [StatW-1:0]     m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgW-1:0]      cfg_data;

  int rot_lo;
  int rot_hi;
  int pris_lo;
  int pris_hi;
  logic signed [PosW-1:0] start_pos [3];

  sample_t samples_due [$];
  sample_t planned [$];
  int mismatches;
  int results_seen;
  int requests_sent;

  // reset limits: t1..t3, duration, mode, typed, expected positions, expected status
  drill_t drills [24] = '{
    '{16'sd12869, 16'sd0, 16'sd0, 7'd4, MODE_LINEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{-16'sd12869, 16'sd0, 16'sd0, 7'd4, MODE_LINEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sd0, 16'sd12869, 16'sd0, 7'd4, MODE_CUBIC, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sd0, -16'sd12869, 16'sd0, 7'd4, MODE_CUBIC, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sd0, 16'sd0, 16'sd615, 7'd4, MODE_LINEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sd0, 16'sd0, -16'sd615, 7'd4, MODE_LINEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sh8000, 16'sd32767, 16'sh8000, 7'd64, MODE_LINEAR, 1'b1,
      16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sd0, 16'sd0, 16'sd0, 7'd0, MODE_LINEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_DURATION},
    '{16'sd12868, -16'sd12868, 16'sd614, 7'd65, MODE_CUBIC, 1'b1,
      16'sd0, 16'sd0, 16'sd0, ST_DURATION},
    '{16'sd0, 16'sd0, 16'sd0, 7'd127, MODE_LINEAR, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_DURATION},
    '{16'sd0, 16'sd0, 16'sd0, 7'd4, MODE_BAD2, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_MODE},
    '{16'sd0, 16'sd0, 16'sd0, 7'd4, MODE_BAD3, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_MODE},
    '{16'sd32767, 16'sd0, 16'sd0, 7'd0, MODE_BAD3, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_LIMIT},
    '{16'sd0, 16'sd0, 16'sd0, 7'd0, MODE_BAD2, 1'b1, 16'sd0, 16'sd0, 16'sd0, ST_DURATION},
    '{16'sd100, -16'sd200, 16'sd300, 7'd1, MODE_LINEAR, 1'b1,
      16'sd100, -16'sd200, 16'sd300, ST_OK},
    '{-16'sd12868, 16'sd12868, -16'sd614, 7'd8, MODE_BAD2, 1'b1,
      16'sd100, -16'sd200, 16'sd300, ST_MODE},
    '{16'sd12868, -16'sd12868, 16'sd614, 7'd4, MODE_LINEAR, 1'b0,
      16'sd0, 16'sd0, 16'sd0, ST_OK},
    '{-16'sd12868, 16'sd12868, -16'sd614, 7'd5, MODE_CUBIC, 1'b0,
      16'sd0, 16'sd0, 16'sd0, ST_OK},
    '{16'sd0, 16'sd0, 16'sd0, 7'd64, MODE_LINEAR, 1'b0, 16'sd0, 16'sd0, 16'sd0, ST_OK},
    '{16'sd1234, -16'sd4321, -16'sd7, 7'd64, MODE_CUBIC, 1'b0,
      16'sd0, 16'sd0, 16'sd0, ST_OK},
    '{16'sd1234, -16'sd4321, -16'sd7, 7'd3, MODE_LINEAR, 1'b0,
      16'sd0, 16'sd0, 16'sd0, ST_OK},
    // odd deltas over two steps land exactly on half units, both signs
    '{16'sd1235, -16'sd4324, -16'sd2, 7'd2, MODE_LINEAR, 1'b0,
      16'sd0, 16'sd0, 16'sd0, ST_OK},
    '{16'sd1236, -16'sd4327, 16'sd3, 7'd2, MODE_CUBIC, 1'b0,
      16'sd0, 16'sd0, 16'sd0, ST_OK},
    '{-16'sd5, 16'sd6, -16'sd7, 7'd1, MODE_CUBIC, 1'b0, 16'sd0, 16'sd0, 16'sd0, ST_OK}
  };

  joint_trajectory_interpolator_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // samples of one move request, or its single error result
  function automatic void plan_samples(input drill_t row);
    logic signed [PosW-1:0] goal [3];
    logic signed [PosW-1:0] pos [3];
    sample_t s;
    longint delta;
    longint mag;
    longint num;
    longint den;
    longint q;
    int n;
    planned.delete();
    goal[0] = row.t1;
    goal[1] = row.t2;
    goal[2] = row.t3;
    n = int'(row.dur);
    s.p1 = start_pos[0];
    s.p2 = start_pos[1];
    s.p3 = start_pos[2];
    s.fin = 1'b1;
    if (goal[0] < rot_lo || goal[0] > rot_hi || goal[1] < rot_lo || goal[1] > rot_hi ||
        goal[2] < pris_lo || goal[2] > pris_hi) begin
      s.st = ST_LIMIT;
      planned = {planned, s};
      return;
    end
    if (n == 0 || n > MaxStepsDefault) begin
      s.st = ST_DURATION;
      planned = {planned, s};
      return;
    end
    if (row.mode != MODE_LINEAR && row.mode != MODE_CUBIC) begin
      s.st = ST_MODE;
      planned = {planned, s};
      return;
    end
    for (int k = 1; k <= n; k++) begin
      if (row.mode == MODE_LINEAR) begin
        num = k;
        den = n;
      end else begin
        num = longint'(k) * k * (3 * n - 2 * k);
        den = longint'(n) * n * n;
      end
      for (int j = 0; j < 3; j++) begin
        delta = longint'(goal[j]) - longint'(start_pos[j]);
        mag = (delta < 0) ? -delta : delta;
        q = (mag * num * 2 + den) / (den * 2);
        if (delta < 0) q = -q;
        pos[j] = PosW'(longint'(start_pos[j]) + q);
      end
      s.p1 = pos[0];
      s.p2 = pos[1];
      s.p3 = pos[2];
      s.st = ST_OK;
      s.fin = (k == n);
      planned = {planned, s};
    end
    for (int j = 0; j < 3; j++) start_pos[j] = goal[j];
  endfunction

  function automatic logic signed [PosW-1:0] pick_in(input int lo, input int hi);
    logic signed [PosW-1:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (lo > hi) v = PosW'($urandom);
    else if (r < 5) v = PosW'(lo);
    else if (r < 10) v = PosW'(hi);
    else v = PosW'(lo + int'($urandom_range(0, hi - lo)));
    return v;
  endfunction

  function automatic logic [DurW-1:0] pick_steps();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return DurW'($urandom_range(1, 8));
    if (r < 92) return DurW'($urandom_range(9, 32));
    if (r < 96) return DurW'(MaxStepsDefault);
    return DurW'($urandom_range(33, 64));
  endfunction

  task automatic note_mismatch(input string what, input sample_t want, input sample_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %0d %0d %0d st=%0d last=%0b, got %0d %0d %0d st=%0d last=%0b",
               what, want.p1, want.p2, want.p3, want.st, want.fin,
               seen.p1, seen.p2, seen.p3, seen.st, seen.fin);
  endtask

  task automatic offer(input drill_t row);
    sample_t s;
    @(negedge clk);
    if (requests_sent < 250 || requests_sent >= 320)
      while ($urandom_range(0, 99) < 27) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end
    s_axis_tdata <= {1'b0, row.dur, row.t3, row.t2, row.t1};
    s_axis_tuser <= row.mode;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
    plan_samples(row);
    if (row.typed) begin
      s.p1 = row.e1;
      s.p2 = row.e2;
      s.p3 = row.e3;
      s.st = row.est;
      s.fin = 1'b1;
      samples_due = {samples_due, s};
    end else begin
      foreach (planned[i]) samples_due = {samples_due, planned[i]};
    end
  endtask

  task automatic finish_phase();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_limits(input logic signed [PosW-1:0] r_lo, r_hi, p_lo, p_hi);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROT_LO;
    cfg_data <= r_lo;
    @(negedge clk);
    cfg_index <= CFG_ROT_HI;
    cfg_data <= r_hi;
    @(negedge clk);
    cfg_index <= CFG_PRIS_LO;
    cfg_data <= p_lo;
    @(negedge clk);
    cfg_index <= CFG_PRIS_HI;
    cfg_data <= p_hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    rot_lo = int'(r_lo);
    rot_hi = int'(r_hi);
    pris_lo = int'(p_lo);
    pris_hi = int'(p_hi);
  endtask

  // mostly legal moves with random content, the rest broken in one way or fully random
  task automatic random_moves(input int count);
    drill_t row;
    repeat (count) begin
      row = '0;
      row.t1 = pick_in(rot_lo, rot_hi);
      row.t2 = pick_in(rot_lo, rot_hi);
      row.t3 = pick_in(pris_lo, pris_hi);
      row.dur = pick_steps();
      row.mode = $urandom_range(0, 1) ? MODE_CUBIC : MODE_LINEAR;
      if ($urandom_range(0, 99) < 25) begin
        case ($urandom_range(0, 3))
          0: begin
            case ($urandom_range(0, 2))
              0: row.t1 = PosW'($urandom);
              1: row.t2 = PosW'($urandom);
              default: row.t3 = PosW'($urandom);
            endcase
          end
          1: row.dur = $urandom_range(0, 1) ? 7'd0 : DurW'($urandom_range(65, 127));
          2: row.mode = $urandom_range(0, 1) ? MODE_BAD2 : MODE_BAD3;
          default: begin
            row.t1 = PosW'($urandom);
            row.t2 = PosW'($urandom);
            row.t3 = PosW'($urandom);
            row.dur = DurW'($urandom_range(0, 127));
            row.mode = ModeW'($urandom_range(0, 3));
          end
        endcase
      end
      offer(row);
    end
  endtask

  always @(posedge clk) begin : monitor
    sample_t seen;
    sample_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.p1 = m_axis_tdata[15:0];
      seen.p2 = m_axis_tdata[31:16];
      seen.p3 = m_axis_tdata[47:32];
      seen.st = status_t'(m_axis_tuser);
      seen.fin = m_axis_tlast;
      results_seen++;
      if (samples_due.size() == 0) begin
        note_mismatch("unrequested sample", '0, seen);
      end else begin
        want = samples_due.pop_front();
        if (seen.p1 !== want.p1 || seen.p2 !== want.p2 || seen.p3 !== want.p3 ||
            seen.st !== want.st || seen.fin !== want.fin)
          note_mismatch("sample mismatch", want, seen);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 60) begin
        held = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (results_seen >= 400 && results_seen < 700) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 27);
      end
    end
  end

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic signed [PosW-1:0] a;
    logic signed [PosW-1:0] b;
    logic signed [PosW-1:0] c;
    logic signed [PosW-1:0] d;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = MODE_LINEAR;
    cfg_we = 1'b0;
    cfg_index = CFG_ROT_LO;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    requests_sent = 0;
    rot_lo = int'(RotLoReset);
    rot_hi = int'(RotHiReset);
    pris_lo = int'(PrisLoReset);
    pris_hi = int'(PrisHiReset);
    for (int j = 0; j < 3; j++) start_pos[j] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (drills[i]) offer(drills[i]);
    finish_phase();
    random_moves(150);
    finish_phase();

    set_limits(16'sh8000, 16'sd32767, 16'sh8000, 16'sd32767);
    random_moves(150);
    finish_phase();

    // single legal point per joint group
    set_limits(16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000);
    random_moves(30);
    finish_phase();

    // crossed rotary limits reject everything
    set_limits(16'sd100, -16'sd100, PrisLoReset, PrisHiReset);
    random_moves(20);
    finish_phase();

    repeat (3) begin
      a = PosW'($urandom);
      b = PosW'($urandom);
      c = PosW'($urandom);
      d = PosW'($urandom);
      if (a > b && $urandom_range(0, 99) < 80) {a, b} = {b, a};
      if (c > d && $urandom_range(0, 99) < 80) {c, d} = {d, c};
      set_limits(a, b, c, d);
      random_moves(32);
      finish_phase();
    end

    if (mismatches == 0 && samples_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/jti_pkg.sv
sv/jti_div.sv
sv/joint_trajectory_interpolator_unit.sv
bench/joint_trajectory_interpolator_unit_tb.sv
